// ===== sv/mips64_special_group_execute_core_defines.svh =====
// assertion macros for the special group execute core
// no dependencies
`ifndef MIPS64_SPECIAL_GROUP_EXECUTE_CORE_DEFINES_SVH
`define MIPS64_SPECIAL_GROUP_EXECUTE_CORE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define MSG_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next cycle implication outside reset
`define MSG_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== sv/msge_pkg.sv =====
// types and constants shared by the special group execute core
// no dependencies
package msge_pkg;
   typedef enum logic [5:0] {
      FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04,
      FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09,
      FN_MOVZ = 6'h0A, FN_MOVN = 6'h0B, FN_SYSCALL = 6'h0C, FN_BREAK = 6'h0D,
      FN_SYNC = 6'h0F, FN_MFHI = 6'h10, FN_MFLO = 6'h12, FN_DSLLV = 6'h14,
      FN_DSRAV = 6'h17, FN_MULT = 6'h18, FN_DIV = 6'h1A, FN_DIVU = 6'h1B,
      FN_ADDU = 6'h21, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
      FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B, FN_DADDU = 6'h2D,
      FN_DSLL = 6'h38, FN_DSRL = 6'h3A, FN_DSLL32 = 6'h3C, FN_DSRL32 = 6'h3E,
      FN_DSRA32 = 6'h3F
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DIVFIX, ST_OUT
   } state_type;

   typedef struct packed {
      logic [5:0]  func;
      logic [63:0] rs_value;
      logic [63:0] rt_value;
      logic [4:0]  rd_index;
      logic [4:0]  shift_amount;
      logic [31:0] pc;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [4:0]  write_index;
      logic [63:0] write_value;
      logic        jump_taken;
      logic [31:0] jump_target;
      logic        syscall_trap;
      logic        divide_fault;
      logic        unknown_func;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic exec;     // execute: latch result and product
      logic mul;      // register product into hi/lo
      logic div_init; // start divider
      logic div_step; // one quotient bit
      logic div_fix;  // sign fixup and hi/lo write
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } sts_type;

   localparam logic [31:0] MIN_INT32 = 32'h8000_0000;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   function automatic logic [63:0] sext32(input logic [31:0] x);
      return {{32{x[31]}}, x};
   endfunction
endpackage

// ===== sv/msge_if.sv =====
// valid/ready channel carrying one word of type t
// depends on nothing but the payload type given as parameter
interface msge_if #(parameter type T = logic) ();
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/msge_ctrl.sv =====
// controller state machine for the special group execute core
// depends on msge_pkg
module msge_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  msge_pkg::sts_type  sts,
   output msge_pkg::cmd_type  cmd
);
   import msge_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            priority if (sts.is_mul) state_in = ST_MUL;
            else if (sts.is_div) state_in = ST_DIV;
            else state_in = ST_OUT;
         end
         ST_MUL: state_in = ST_OUT;
         ST_DIV: if (sts.div_last) state_in = ST_DIVFIX;
         ST_DIVFIX: state_in = ST_OUT;
         ST_OUT: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cmd.div_init = sts.is_div;
         end
         ST_MUL: cmd.mul = 1'b1;
         ST_DIV: cmd.div_step = 1'b1;
         ST_DIVFIX: cmd.div_fix = 1'b1;
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ===== sv/msge_datapath.sv =====
// datapath: operand registers, alu, shifter, multiplier, radix-2 divider, hi/lo
// depends on msge_pkg
module msge_datapath (
   input  logic               clock,
   input  logic               reset,
   input  msge_pkg::cmd_type  cmd,
   input  msge_pkg::req_type  req_data,
   output msge_pkg::sts_type  sts,
   output msge_pkg::rsp_type  rsp_data
);
   import msge_pkg::*;

   req_type     op_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [63:0] hi_ff, lo_ff;
   logic [63:0] prod_ff;
   logic [31:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  cnt_ff;
   logic        qneg_ff, rneg_ff, dsigned_ff, dzero_ff, dovf_ff;

   logic [5:0]  fn;
   logic [63:0] rs, rt;
   logic [5:0]  amt;
   logic [63:0] sh_l, sh_rl, sh_ra, val;
   logic        we;

   assign fn = op_ff.func;
   assign rs = op_ff.rs_value;
   assign rt = op_ff.rt_value;
   assign sts.is_mul = (fn == FN_MULT);
   assign sts.is_div = (fn == FN_DIV) || (fn == FN_DIVU);
   assign sts.div_last = (cnt_ff == 5'd0);
   assign rsp_data = rsp_ff;

   // one shared 64-bit shifter, input prepared per op
   logic [63:0] sh_src;
   always_comb begin
      sh_src = rt;
      amt = {1'b0, op_ff.shift_amount};
      unique case (fn)
         FN_SLLV, FN_SRLV, FN_SRAV: amt = {1'b0, rs[4:0]};
         FN_DSLLV, FN_DSRAV: amt = rs[5:0];
         FN_DSLL32, FN_DSRL32, FN_DSRA32: amt = {1'b1, op_ff.shift_amount};
         default: ;
      endcase
      unique case (fn)
         FN_SRL, FN_SRLV: sh_src = {32'd0, rt[31:0]};
         FN_SRA, FN_SRAV: sh_src = sext32(rt[31:0]);
         default: ;
      endcase
      sh_l  = sh_src << amt;
      sh_rl = sh_src >> amt;
      sh_ra = $unsigned($signed(sh_src) >>> amt);
   end

   always_comb begin
      we = 1'b1;
      val = '0;
      rsp_in = '0;
      unique case (fn)
         FN_SLL, FN_SLLV: val = sext32(sh_l[31:0]);
         FN_SRL, FN_SRLV: val = sext32(sh_rl[31:0]);
         FN_SRA, FN_SRAV, FN_DSRAV, FN_DSRA32: val = sh_ra;
         FN_DSLLV, FN_DSLL, FN_DSLL32: val = sh_l;
         FN_DSRL, FN_DSRL32: val = sh_rl;
         FN_JR: begin
            we = 1'b0;
            rsp_in.jump_taken = 1'b1;
            rsp_in.jump_target = rs[31:0];
         end
         FN_JALR: begin
            val = {32'd0, op_ff.pc + 32'd8};
            rsp_in.jump_taken = 1'b1;
            rsp_in.jump_target = rs[31:0];
         end
         FN_MOVZ: begin we = (rt == 64'd0); val = rs; end
         FN_MOVN: begin we = (rt != 64'd0); val = rs; end
         FN_SYSCALL: begin we = 1'b0; rsp_in.syscall_trap = 1'b1; end
         FN_BREAK, FN_SYNC: we = 1'b0;
         FN_MFHI: val = hi_ff;
         FN_MFLO: val = lo_ff;
         FN_MULT: we = 1'b0; // written in mul cycle
         FN_DIV: begin
            we = 1'b0;
            rsp_in.divide_fault = (rt[31:0] == 32'd0) &&
                                  !((rs[31:0] == MIN_INT32) && (rt[31:0] == 32'hFFFF_FFFF));
         end
         FN_DIVU: we = 1'b0;
         FN_ADDU: val = sext32(rs[31:0] + rt[31:0]);
         FN_SUBU: val = sext32(rs[31:0] - rt[31:0]);
         FN_AND: val = rs & rt;
         FN_OR: val = rs | rt;
         FN_NOR: val = ~(rs | rt);
         FN_SLT: val = {63'd0, ($signed(rs) < $signed(rt))};
         FN_SLTU: val = {63'd0, (rs < rt)};
         FN_DADDU: val = rs + rt;
         default: begin we = 1'b0; rsp_in.unknown_func = 1'b1; end
      endcase
      rsp_in.write_enable = we;
      rsp_in.write_index = we ? op_ff.rd_index : 5'd0;
      rsp_in.write_value = we ? val : 64'd0;
   end

   // signed 32x32 multiply, full 64-bit product
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   assign mul_a = rs[31:0];
   assign mul_b = rt[31:0];
   assign mul_p = mul_a * mul_b;

   // divider step: restoring, one bit per cycle on magnitudes
   logic [32:0] trial;
   logic [31:0] rem_sh;
   logic [31:0] a_mag, b_mag;
   logic        sgn;
   assign sgn = (fn == FN_DIV);
   assign a_mag = (sgn && rs[31]) ? 32'd0 - rs[31:0] : rs[31:0];
   assign b_mag = (sgn && rt[31]) ? 32'd0 - rt[31:0] : rt[31:0];
   assign rem_sh = {rem_ff[30:0], quo_ff[31]};
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) op_ff <= req_data;
      if (cmd.exec) rsp_ff <= rsp_in;
      if (cmd.mul) begin
         rsp_ff.write_enable <= 1'b1;
         rsp_ff.write_index <= op_ff.rd_index;
         rsp_ff.write_value <= sext32(prod_ff[31:0]);
      end
      if (cmd.exec) prod_ff <= mul_p;
      if (cmd.div_init) begin
         quo_ff <= a_mag;
         rem_ff <= '0;
         dvs_ff <= b_mag;
         cnt_ff <= 5'd31;
         qneg_ff <= sgn && (rs[31] ^ rt[31]);
         rneg_ff <= sgn && rs[31];
         dsigned_ff <= sgn;
         dzero_ff <= (rt[31:0] == 32'd0);
         dovf_ff <= sgn && (rs[31:0] == MIN_INT32) && (rt[31:0] == 32'hFFFF_FFFF);
      end
      if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 5'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (cmd.mul) begin
         lo_ff <= sext32(prod_ff[31:0]);
         hi_ff <= sext32(prod_ff[63:32]);
      end else if (cmd.div_fix) begin
         priority if (dovf_ff) begin
            lo_ff <= sext32(MIN_INT32);
            hi_ff <= '0;
         end else if (dzero_ff && dsigned_ff) begin
            lo_ff <= lo_ff;
         end else if (dzero_ff) begin
            lo_ff <= ALL_ONES;
            hi_ff <= sext32(rs[31:0]);
         end else begin
            lo_ff <= sext32(qneg_ff ? 32'd0 - quo_ff : quo_ff);
            hi_ff <= sext32(rneg_ff ? 32'd0 - rem_ff : rem_ff);
         end
      end
   end
endmodule

// ===== sv/mips64_special_group_execute_core.sv =====
// mips64 special group execute core: one instruction word in, one result word out.
// req channel carries msge_pkg::req_type (func, rs/rt values, rd, sa, pc);
// rsp channel carries msge_pkg::rsp_type (write port, jump, syscall, faults).
// one word is handled at a time: req_ready is high only while the core is idle.
// after accept, each word passes the execute state and then the output state;
// mult adds a state that writes the registered 32x32 product, and div/divu
// add 32 radix-2 steps plus sign fixup; rsp_valid rises in the output state.
// a new word waits until the previous one is done: the divider loop sets the pace
// for div/divu, and the controller's idle/execute/output sequence otherwise.
// a result holds in the output register while rsp_ready is low, and no new
// word is taken until it is delivered.
// synchronous reset clears the controller and the hi/lo pair to zero.
// depends on msge_pkg, msge_if, msge_ctrl, msge_datapath and the defines header.
`include "mips64_special_group_execute_core_defines.svh"
module mips64_special_group_execute_core (
   input logic clock,
   input logic reset,
   msge_if.sink   req,
   msge_if.source rsp
);
   import msge_pkg::*;

   cmd_type cmd;
   sts_type sts;

   msge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   msge_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req.data),
      .sts      (sts),
      .rsp_data (rsp.data)
   );

   // no new word while a result waits
   `MSG_ASSERT_IMPL(a_no_overlap, clock, reset, rsp.valid, !req.ready, "accept during output")
   // a result stays until taken
   `MSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid,
                    "result dropped")
   // at most one of write enable, syscall trap, divide fault and unknown func
   `MSG_ASSERT_IMPL(a_flags_excl, clock, reset, rsp.valid,
                    $onehot0({rsp.data.write_enable, rsp.data.syscall_trap,
                              rsp.data.divide_fault, rsp.data.unknown_func}),
                    "conflicting result flags")
endmodule
